### design/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for the radix digit converter
// Field widths, base limits, the divider status bundle and the digit glyphs.
// ----------------------------------------------------------------------------
package itrd_pkg;

  // Fixed widths of the beat payloads
  localparam int unsigned ValueW = 64;
  localparam int unsigned BaseW  = 5;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 4;

  // Accepted radix range
  localparam logic [BaseW-1:0] BaseMin = BaseW'(2);
  localparam logic [BaseW-1:0] BaseMax = BaseW'(16);

  // Character sent for a zero value
  localparam logic [CharW-1:0] CharZero = 8'h30;

  // Status from the serial divider to the sequencer
  typedef struct packed {
    logic              digit_valid; // remainder digit final this cycle
    logic [DigitW-1:0] digit;       // remainder of the division just finished
    logic              quo_zero;    // quotient after that division is zero
  } itrd_div_status_t;

  // Map a digit to its upper-case ASCII glyph
  function automatic logic [CharW-1:0] itrd_glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] ch;
    if (d < DigitW'(10)) begin
      ch = 8'h30 + CharW'(d);
    end else begin
      ch = 8'h37 + CharW'(d);
    end
    return ch;
  endfunction

endpackage

### design/itrd_if.sv
// ----------------------------------------------------------------------------
// itrd_in_if / itrd_out_if: valid/ready channels of the radix digit converter
// The input channel carries a value and a base; the output channel one digit.
// ----------------------------------------------------------------------------
interface itrd_in_if
  import itrd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic        [BaseW-1:0]  base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface itrd_out_if
  import itrd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             negative;
  logic             last;
  logic             error;

  modport source (output valid, output digit_char, output negative, output last,
                  output error, input ready);
  modport sink   (input valid, input digit_char, input negative, input last,
                  input error, output ready);
endinterface

### design/itrd_serial_div.sv
// ----------------------------------------------------------------------------
// itrd_serial_div: bit-serial restoring divider by a small radix
// Shifts the quotient one bit per cycle through a 4-bit remainder, giving a
// digit after each full pass over the quotient; keeps dividing while the sequencer asks.
// ----------------------------------------------------------------------------
module itrd_serial_div
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [VALUE_BITS-1:0]  mag_i,
  input  logic [BaseW-1:0]       base_i,
  input  logic                   keep_i,
  output itrd_div_status_t       status_o
);

  localparam int unsigned BitW = $clog2(VALUE_BITS);
  localparam logic [BitW-1:0] BitLast = BitW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DigitW-1:0]     rem_q, rem_d;
  logic [BaseW-1:0]      base_q;
  logic [BitW-1:0]       bit_q, bit_d;
  logic                  busy_q, busy_d;
  logic [BaseW-1:0]      rem_shift;
  logic                  ge;
  logic                  digit_done;

  // One restoring step: bring in the next quotient bit, subtract if it fits
  always_comb begin
    rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
    ge        = (rem_shift >= base_q);
    rem_d     = ge ? DigitW'(rem_shift - base_q) : DigitW'(rem_shift);
    quo_d     = {quo_q[VALUE_BITS-2:0], ge};
  end

  assign digit_done = busy_q && (bit_q == BitLast);

  // Advance the bit counter; restart for the next digit or drop busy
  always_comb begin
    bit_d  = bit_q + BitW'(1);
    busy_d = busy_q;
    if (digit_done) begin
      bit_d  = '0;
      busy_d = keep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
    end else if (load_i) begin
      quo_q  <= mag_i;
      rem_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      quo_q  <= quo_d;
      rem_q  <= digit_done ? '0 : rem_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
    end
  end

  // Hold the base for the whole conversion
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      base_q <= base_i;
    end
  end

  assign status_o.digit_valid = digit_done;
  assign status_o.digit       = rem_d;
  assign status_o.quo_zero    = (quo_d == '0);

endmodule

### design/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to ASCII digits in base 2..16
// Converts the magnitude of a value to digits, most significant first.
// ----------------------------------------------------------------------------
// One item is converted at a time. The bit-serial divider finds the digits
// least significant first and writes them to the reversal store; each digit is
// then read back from the store and sent, and the output may stall the send. A
// zero value or a bad base gives its single beat in the cycle after it is
// accepted. Digits come out most significant first with last on the final one;
// negative flags a negative value on every beat instead of a '-' character. A
// base outside 2..16 yields one beat with error and last set. Only the low
// VALUE_BITS bits of value are used, and at most the MAX_DIGITS least
// significant digits are sent.
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itrd_in_if.sink     in_i,
  itrd_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_DIGITS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } itrd_state_e;

  itrd_state_e state_q, state_d;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                  sign_q, sign_d;
  logic                  err_q, err_d;
  logic [DigitW-1:0]     rd_data_q;
  logic [DigitW-1:0]     store_q [MAX_DIGITS];

  logic [VALUE_BITS-1:0] val_low;
  logic [VALUE_BITS-1:0] mag;
  logic                  val_neg;
  logic                  base_bad;
  logic                  in_beat;
  logic                  div_load;
  logic                  div_keep;
  logic                  store_we;
  logic                  rd_en;
  logic                  zero_load;
  itrd_div_status_t      div_st;

  // Magnitude of the incoming value
  always_comb begin
    val_low  = in_i.value[VALUE_BITS-1:0];
    val_neg  = val_low[VALUE_BITS-1];
    mag      = val_neg ? (~val_low + VALUE_BITS'(1)) : val_low;
    base_bad = (in_i.base < BaseMin) || (in_i.base > BaseMax);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;

  // Keep dividing while quotient is nonzero and the store has room
  assign div_keep = !div_st.quo_zero && (cnt_q != CntLast);

  itrd_serial_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (div_load),
    .mag_i    (mag),
    .base_i   (in_i.base),
    .keep_i   (div_keep),
    .status_o (div_st)
  );

  // Sequencer: convert, then read back the store from the top digit down
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    sign_d    = sign_q;
    err_d     = err_q;
    div_load  = 1'b0;
    store_we  = 1'b0;
    rd_en     = 1'b0;
    zero_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          rd_ptr_d = '0;
          if (base_bad) begin
            err_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            err_d  = 1'b0;
            sign_d = val_neg;
            cnt_d  = '0;
            if (mag == '0) begin
              zero_load = 1'b1;
              state_d   = S_EMIT;
            end else begin
              div_load = 1'b1;
              state_d  = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_st.digit_valid) begin
          store_we = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
          if (!div_keep) begin
            rd_ptr_d = cnt_q[IdxW-1:0];
            state_d  = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_o.ready) begin
          if (rd_ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - IdxW'(1);
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_ptr_q <= '0;
      sign_q   <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
      sign_q   <= sign_d;
      err_q    <= err_d;
    end
  end

  // Reversal store: write digits as found, read back in reverse order
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cnt_q[IdxW-1:0]] <= div_st.digit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_q[rd_ptr_q];
    end else if (zero_load) begin
      rd_data_q <= '0;
    end
  end

  // Output beat
  assign out_o.valid      = (state_q == S_EMIT);
  assign out_o.digit_char = err_q ? '0 : itrd_glyph(rd_data_q);
  assign out_o.negative   = sign_q && !err_q;
  assign out_o.last       = (rd_ptr_q == '0);
  assign out_o.error      = err_q;

  // The block never takes a new item while a digit beat is pending
  a_no_accept_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a digit beat is pending");

  // An error beat is always the only beat of its item
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.last)
    else $error("error beat without last");

  // Digits are only produced during conversion, within store bounds
  a_digit_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.digit_valid |-> (state_q == S_DIV) && (cnt_q < CntW'(MAX_DIGITS)))
    else $error("divider digit outside conversion or beyond store depth");

  // The final digit hands over to readback
  a_stop_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.digit_valid && !div_keep |=> (state_q == S_READ))
    else $error("conversion end did not start readback");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the radix digit converter
// Drives signed values and bases into the block, predicts the ASCII digit
// beats of every conversion and checks each output beat field by field in
// order. Both channels idle at random; a cycle counter bounds the run.
// ----------------------------------------------------------------------------

module tb_top;
  import itrd_pkg::*;

  // Expected-beat store and digit predictor for the converter
  class radix_scoreboard;

    typedef struct packed {
      logic [CharW-1:0] digit_char;
      logic             negative;
      logic             last_flag;
      logic             error_flag;
    } digit_beat_t;

    localparam int unsigned MaxDigits = 64;

    digit_beat_t pending_beats[$];
    int          mismatch_count;
    string       digit_glyphs;

    function new();
      pending_beats  = {};
      mismatch_count = 0;
      digit_glyphs   = "0123456789ABCDEF";
    endfunction

    // Work out the digit beats of one accepted conversion and queue them
    function void add_conversion(logic signed [ValueW-1:0] value, logic [BaseW-1:0] base);
      logic [ValueW-1:0] magnitude;
      logic [DigitW-1:0] reversed[$];
      logic              neg;
      digit_beat_t       beat;
      int                idx;
      reversed = {};
      // Bad base: one error beat, nothing else
      if (base < BaseMin || base > BaseMax) begin
        beat = '{digit_char: '0, negative: 1'b0, last_flag: 1'b1, error_flag: 1'b1};
        pending_beats.push_back(beat);
        return;
      end
      neg       = value[ValueW-1];
      magnitude = neg ? (~value + 1'b1) : value;
      // Zero value: single '0' digit
      if (magnitude == '0) begin
        beat = '{digit_char: CharZero, negative: neg, last_flag: 1'b1, error_flag: 1'b0};
        pending_beats.push_back(beat);
        return;
      end
      // Divide repeatedly, least significant digit first
      while (magnitude != '0 && reversed.size() < MaxDigits) begin
        reversed.push_back(DigitW'(magnitude % ValueW'(base)));
        magnitude = magnitude / ValueW'(base);
      end
      // Emit most significant first
      for (idx = reversed.size() - 1; idx >= 0; idx--) begin
        beat.digit_char = CharW'(digit_glyphs[reversed[idx]]);
        beat.negative   = neg;
        beat.last_flag  = (idx == 0);
        beat.error_flag = 1'b0;
        pending_beats.push_back(beat);
      end
    endfunction

    // Compare one field and report a mismatch
    function void check_field(string field, logic [CharW-1:0] exp_val,
                              logic [CharW-1:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
                 act_val);
        mismatch_count++;
      end
    endfunction

    // Check one accepted output beat against the oldest expectation
    function void check_digit(digit_beat_t actual);
      digit_beat_t wanted;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, actual);
        mismatch_count++;
        return;
      end
      wanted = pending_beats.pop_front();
      check_field("digit_char", wanted.digit_char, actual.digit_char);
      check_field("negative", CharW'(wanted.negative), CharW'(actual.negative));
      check_field("last", CharW'(wanted.last_flag), CharW'(actual.last_flag));
      check_field("error", CharW'(wanted.error_flag), CharW'(actual.error_flag));
    endfunction
  endclass

  localparam int unsigned IdlePct    = 23;
  localparam int unsigned RandItems  = 120;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainWait  = 4300;

  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic no_idle;
  int unsigned cycle_count;

  radix_scoreboard board = new();

  itrd_in_if  in_if();
  itrd_out_if out_if();

  integer_to_radix_digits uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Generate the clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the output channel at random
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_digit('{digit_char: out_if.digit_char, negative: out_if.negative,
                          last_flag: out_if.last, error_flag: out_if.error});
    end
  end

  // Offer one conversion after a random gap and hold it until accepted
  task automatic send_conversion(input logic signed [ValueW-1:0] value,
                                 input logic [BaseW-1:0] base);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.base  <= base;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.add_conversion(value, base);
  endtask

  // Hold off the input until every expected beat has come
  task automatic drain_digits();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_beats.size() != 0);
  endtask

  // Pick a random conversion, mostly short magnitudes and valid bases
  task automatic send_random_conversion();
    logic signed [ValueW-1:0] value;
    logic [BaseW-1:0]         base;
    int unsigned              kind;
    int unsigned              width;
    int unsigned              pick;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      width = $urandom_range(1, 16);
      value = ValueW'($urandom & ((32'd1 << width) - 1));
    end else if (kind < 80) begin
      value = {$urandom, $urandom};
    end else if (kind < 88) begin
      width = $urandom_range(17, 40);
      value = {$urandom, $urandom} & ((64'd1 << width) - 1);
    end else if (kind < 93) begin
      value = '0;
    end else begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: value = MinValue;
        1: value = MaxValue;
        2: value = 64'sd1;
        default: value = -64'sd1;
      endcase
    end
    if (kind < 88 && $urandom_range(0, 1) == 1) begin
      value = -value;
    end
    // Mostly legal bases, some out of range
    if ($urandom_range(0, 99) < 10) begin
      pick = $urandom_range(0, 16);
      base = (pick < 2) ? BaseW'(pick) : BaseW'(pick + 15);
    end else begin
      base = BaseW'($urandom_range(BaseMin, BaseMax));
    end
    send_conversion(value, base);
  endtask

  initial begin
    int unsigned n;
    rst_ni       = 1'b0;
    no_idle      = 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.base  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, extremes, all glyphs, bad bases
    send_conversion('0, BaseW'(10));
    send_conversion(64'sd1, BaseW'(2));
    send_conversion(-64'sd1, BaseW'(16));
    send_conversion(MaxValue, BaseW'(2));
    send_conversion(MinValue, BaseW'(2));
    send_conversion(MinValue, BaseW'(16));
    send_conversion(MinValue, BaseW'(10));
    send_conversion(MaxValue, BaseW'(16));
    send_conversion(MaxValue, BaseW'(10));
    send_conversion(64'sh0123456789ABCDEF, BaseW'(16));
    send_conversion(64'shFEDCBA9876543210, BaseW'(16));
    send_conversion(-64'sd255, BaseW'(15));
    send_conversion(MaxValue, BaseW'(3));
    send_conversion(MinValue, BaseW'(7));
    send_conversion(64'sd143, BaseW'(12));
    send_conversion(-64'sd1, BaseW'(13));
    send_conversion(-64'sd12345, BaseW'(0));
    send_conversion(64'sd77, BaseW'(1));
    send_conversion(MinValue, BaseW'(17));
    send_conversion(-64'sd1, BaseW'(31));
    send_conversion('0, BaseW'(2));
    drain_digits();

    // Random conversions, with a stretch of full throughput
    for (n = 0; n < RandItems; n++) begin
      no_idle = (n >= 50 && n < 90);
      if (n == 100) begin
        drain_digits();
      end
      send_random_conversion();
    end
    no_idle = 1'b0;

    drain_digits();
    repeat (DrainWait) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
